// ===== sv/bse_pkg.sv =====
package bse_pkg;

	// defaults for the top-level parameters
	localparam int MAX_TILES_DEF      = 64;
	localparam int VALUE_BITS_DEF     = 24;
	localparam int EDGE_TOLERANCE_DEF = 25;

	localparam int KNOTS_PER_TILE = 25;
	localparam int GRID           = 5;

	// field widths
	localparam int COORD_W = 16;
	localparam int SIZE_W  = 13;
	localparam int TILES_W = 4;
	localparam int IDX_W   = 11;
	localparam int KNOT_W  = 24;
	localparam int OUT_W   = 24;
	localparam int BLEND_W = 17;
	localparam int FRAC_W  = 18;

	// shared divider
	localparam int DIV_NUM_W = 32;
	localparam int DIV_DEN_W = 13;

	// opcodes
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_EVAL  = 1'b1;

	typedef enum logic [2:0] {
		REG_ORIGIN_X     = 3'd0,
		REG_ORIGIN_Y     = 3'd1,
		REG_IMAGE_WIDTH  = 3'd2,
		REG_IMAGE_HEIGHT = 3'd3,
		REG_TILE_COLUMNS = 3'd4,
		REG_TILE_ROWS    = 3'd5,
		REG_TILE_WIDTH   = 3'd6,
		REG_TILE_HEIGHT  = 3'd7
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIVX,
		ST_DIVY,
		ST_FRX,
		ST_FRY,
		ST_BLX_SQ,
		ST_BLX,
		ST_BLY_SQ,
		ST_BLY,
		ST_TILE,
		ST_MAC,
		ST_DRAIN,
		ST_FINAL
	} state_t;

	typedef struct packed {
		logic                 start;
		logic [DIV_NUM_W-1:0] num;
		logic [DIV_DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic                 done;
		logic [DIV_NUM_W-1:0] quo;
		logic [DIV_DEN_W-1:0] rem;
	} div_rsp_t;

	typedef logic [GRID-1:0][BLEND_W-1:0] blend5_t;

	typedef struct packed {
		logic              ok;
		logic [SIZE_W-1:0] val;
	} clamp_t;

	// offset clamp to [0, size-1] within the edge tolerance
	function automatic clamp_t clamp_axis(logic signed [18:0] p, logic [SIZE_W-1:0] size,
			logic signed [18:0] tol);
		clamp_t            r;
		logic signed [18:0] sz;
		sz    = $signed({6'b0, size});
		r.ok  = 1'b1;
		r.val = p[SIZE_W-1:0];
		if (p < 0) begin
			r.ok  = p > -tol;
			r.val = '0;
		end else if (p >= sz) begin
			r.ok  = p < sz + tol;
			r.val = size - SIZE_W'(1);
		end
		return r;
	endfunction

	// quadratic open uniform blends in Q16 from segment, t, t^2 and (1-t)^2
	function automatic blend5_t blend(logic [1:0] seg, logic [15:0] t, logic [31:0] t2,
			logic [32:0] omt2);
		logic [34:0] d [GRID];
		logic [34:0] tt, t2w, om, one2, s;
		blend5_t     b;
		tt   = 35'(t);
		t2w  = 35'(t2);
		om   = 35'(omt2);
		one2 = 35'(1) << 32;
		for (int k = 0; k < GRID; k++) d[k] = '0;
		case (seg)
			2'd0: begin
				d[0] = om << 1;
				d[1] = (tt << 18) - t2w - (t2w << 1);
				d[2] = t2w;
			end
			2'd1: begin
				d[1] = om;
				d[2] = one2 + (tt << 17) - (t2w << 1);
				d[3] = t2w;
			end
			2'd2: begin
				d[2] = om;
				d[3] = one2 + (tt << 17) - t2w - (t2w << 1);
				d[4] = t2w << 1;
			end
			default: begin
				d[4] = one2 << 1;
			end
		endcase
		for (int k = 0; k < GRID; k++) begin
			s    = d[k] + 35'(65536);
			b[k] = s[33:17];
		end
		return b;
	endfunction

endpackage

// ===== sv/bse_div.sv =====
// restoring divider, one quotient bit per cycle
module bse_div (
	input  logic                clk,
	input  logic                arst_n,
	input  bse_pkg::div_req_t   req,
	output bse_pkg::div_rsp_t   rsp
);

	localparam int CNT_W = $clog2(bse_pkg::DIV_NUM_W);

	logic [bse_pkg::DIV_NUM_W-1:0] quo_q;
	logic [bse_pkg::DIV_DEN_W-1:0] rem_q;
	logic [bse_pkg::DIV_DEN_W-1:0] den_q;
	logic [CNT_W-1:0]              cnt_q;
	logic                          busy_q;
	logic                          done_q;
	logic [bse_pkg::DIV_DEN_W:0]   r2;
	logic [bse_pkg::DIV_DEN_W:0]   diff;
	logic                          ge;

	assign r2   = {rem_q, quo_q[bse_pkg::DIV_NUM_W-1]};
	assign ge   = r2 >= {1'b0, den_q};
	assign diff = r2 - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(bse_pkg::DIV_NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end else if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			quo_q <= {quo_q[bse_pkg::DIV_NUM_W-2:0], ge};
			rem_q <= ge ? diff[bse_pkg::DIV_DEN_W-1:0] : r2[bse_pkg::DIV_DEN_W-1:0];
		end else if (req.start) begin
			quo_q <= req.num;
			rem_q <= '0;
			den_q <= req.den;
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;
	assign rsp.rem  = rem_q;

endmodule

// ===== sv/bse_knot_ram.sv =====
// control value store, one write and one registered read port
module bse_knot_ram #(
	parameter int DEPTH  = bse_pkg::MAX_TILES_DEF * bse_pkg::KNOTS_PER_TILE,
	parameter int WIDTH  = bse_pkg::VALUE_BITS_DEF,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== sv/bspline_surface_eval.sv =====
// Quadratic B-spline surface evaluator over a tiled image.
// Write request: ready stays high, gives no result.
// Evaluate request: ready again once its result becomes valid;
// four passes of the shared divider (tile x, tile y, u, v) come before the result.
// Point beyond tolerance: no divider; a result waits while the next is taken.
// Reset (arst_n, async, active low) clears the sequencer, loads register defaults; store kept.
module bspline_surface_eval #(
	parameter int MAX_TILES      = bse_pkg::MAX_TILES_DEF,
	parameter int VALUE_BITS     = bse_pkg::VALUE_BITS_DEF,
	parameter int EDGE_TOLERANCE = bse_pkg::EDGE_TOLERANCE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// request stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,   // knot_index[10:0], knot_value[34:11], point_x[50:35],
	                               // point_y[66:51], zero[71:67]
	input  logic        s_tuser,   // opcode
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // surface_value[23:0]
	output logic        m_tuser,   // outside
	// register writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int DEPTH    = MAX_TILES * bse_pkg::KNOTS_PER_TILE;
	localparam int ADDR_W   = $clog2(DEPTH);
	localparam int TILE_W   = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
	localparam int OUT_BITS = (VALUE_BITS > 24) ? 24 : VALUE_BITS;
	localparam int PROD_W   = VALUE_BITS + 18;
	localparam int ACC_W    = PROD_W + 5;
	localparam int Q_W      = ACC_W - 16;

	localparam logic signed [32:0] KV_HI = 33'((64'sd1 <<< (VALUE_BITS - 1)) - 64'sd1);
	localparam logic signed [32:0] KV_LO = 33'(-(64'sd1 <<< (VALUE_BITS - 1)));
	localparam logic signed [Q_W-1:0] OUT_HI = Q_W'((64'sd1 <<< (OUT_BITS - 1)) - 64'sd1);
	localparam logic signed [Q_W-1:0] OUT_LO = Q_W'(-(64'sd1 <<< (OUT_BITS - 1)));

	// ---------------- request fields ----------------
	logic        [10:0] knot_index;
	logic signed [23:0] knot_value;
	logic signed [15:0] point_x;
	logic signed [15:0] point_y;
	logic               opcode;

	assign knot_index = s_tdata[10:0];
	assign knot_value = $signed(s_tdata[34:11]);
	assign point_x    = $signed(s_tdata[50:35]);
	assign point_y    = $signed(s_tdata[66:51]);
	assign opcode     = s_tuser;

	// ---------------- configuration ----------------
	logic signed [15:0] origin_x_q, origin_y_q;
	logic [12:0]        image_width_q, image_height_q, tile_width_q, tile_height_q;
	logic [3:0]         tile_columns_q, tile_rows_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q     <= '0;
			origin_y_q     <= '0;
			image_width_q  <= 13'd640;
			image_height_q <= 13'd480;
			tile_columns_q <= 4'd1;
			tile_rows_q    <= 4'd1;
			tile_width_q   <= 13'd640;
			tile_height_q  <= 13'd480;
		end else if (cfg_valid) begin
			case (bse_pkg::cfg_reg_t'(cfg_index))
				bse_pkg::REG_ORIGIN_X:     origin_x_q     <= $signed(cfg_data);
				bse_pkg::REG_ORIGIN_Y:     origin_y_q     <= $signed(cfg_data);
				bse_pkg::REG_IMAGE_WIDTH:  image_width_q  <= cfg_data[12:0];
				bse_pkg::REG_IMAGE_HEIGHT: image_height_q <= cfg_data[12:0];
				bse_pkg::REG_TILE_COLUMNS: tile_columns_q <= cfg_data[3:0];
				bse_pkg::REG_TILE_ROWS:    tile_rows_q    <= cfg_data[3:0];
				bse_pkg::REG_TILE_WIDTH:   tile_width_q   <= cfg_data[12:0];
				bse_pkg::REG_TILE_HEIGHT:  tile_height_q  <= cfg_data[12:0];
				default: ;
			endcase
		end
	end

	// sizes below their minimum act as the minimum
	logic [12:0] iw, ih, tw, th;
	logic [3:0]  tc, tr;

	assign iw = (image_width_q < 13'd2) ? 13'd2 : image_width_q;
	assign ih = (image_height_q < 13'd2) ? 13'd2 : image_height_q;
	assign tw = (tile_width_q < 13'd2) ? 13'd2 : tile_width_q;
	assign th = (tile_height_q < 13'd2) ? 13'd2 : tile_height_q;
	assign tc = (tile_columns_q == 4'd0) ? 4'd1 : tile_columns_q;
	assign tr = (tile_rows_q == 4'd0) ? 4'd1 : tile_rows_q;

	// ---------------- request accept ----------------
	bse_pkg::state_t state_q, state_n;

	logic accept, eval_acc;
	assign s_tready = (state_q == bse_pkg::ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign eval_acc = accept && (opcode == bse_pkg::OP_EVAL);

	// knot write goes straight to the store; out-of-range index dropped
	logic              kw_en;
	logic signed [32:0] kv_wide;
	logic signed [32:0] kv_sat;

	assign kw_en   = accept && (opcode == bse_pkg::OP_WRITE) && (32'(knot_index) < DEPTH);
	assign kv_wide = 33'(knot_value);
	assign kv_sat  = (kv_wide > KV_HI) ? KV_HI : ((kv_wide < KV_LO) ? KV_LO : kv_wide);

	// position offset and edge clamp
	logic signed [18:0] dx, dy, tol;
	bse_pkg::clamp_t    cx_cl, cy_cl;

	assign dx    = 19'(point_x) - 19'(origin_x_q);
	assign dy    = 19'(point_y) - 19'(origin_y_q);
	assign tol   = 19'(EDGE_TOLERANCE);
	assign cx_cl = bse_pkg::clamp_axis(dx, iw, tol);
	assign cy_cl = bse_pkg::clamp_axis(dy, ih, tol);

	// ---------------- shared divider ----------------
	bse_pkg::div_req_t div_req;
	bse_pkg::div_rsp_t div_rsp;
	logic              launched_q;
	logic              div_state;

	bse_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// ---------------- datapath registers ----------------
	logic [12:0]          px_q, py_q, cx_q, cy_q, rx_q, ry_q;
	logic [17:0]          sx_q, sy_q;
	logic                 outside_q;
	logic [1:0]           seg_q;
	logic [15:0]          t_q;
	logic [31:0]          t2_q;
	logic [32:0]          omt2_q;
	bse_pkg::blend5_t     bu_q, bv_q;
	logic [ADDR_W-1:0]    base_q;
	logic [4:0]           k_q;
	logic [2:0]           i_q, j_q;
	logic signed [ACC_W-1:0] acc_q;

	// operand select for the divider
	logic [14:0] r3;
	always_comb begin
		div_state     = 1'b0;
		div_req.num   = '0;
		div_req.den   = tw;
		r3            = '0;
		case (state_q)
			bse_pkg::ST_DIVX: begin
				div_state   = 1'b1;
				div_req.num = 32'(px_q);
				div_req.den = tw;
			end
			bse_pkg::ST_DIVY: begin
				div_state   = 1'b1;
				div_req.num = 32'(py_q);
				div_req.den = th;
			end
			bse_pkg::ST_FRX: begin
				// 3u in Q16: r * 3 * 65536 / (size - 1)
				div_state   = 1'b1;
				r3          = 15'(rx_q) + 15'({rx_q, 1'b0});
				div_req.num = {1'b0, r3, 16'b0};
				div_req.den = tw - 13'd1;
			end
			bse_pkg::ST_FRY: begin
				div_state   = 1'b1;
				r3          = 15'(ry_q) + 15'({ry_q, 1'b0});
				div_req.num = {1'b0, r3, 16'b0};
				div_req.den = th - 13'd1;
			end
			default: ;
		endcase
		div_req.start = div_state && !launched_q;
	end

	// blend squares, shared by both axes
	logic [17:0] s_sel;
	logic [16:0] omt;
	assign s_sel = (state_q == bse_pkg::ST_BLY_SQ) ? sy_q : sx_q;
	assign omt   = 17'd65536 - 17'(s_sel[15:0]);

	// tile select
	logic [12:0]       cxc, cyc;
	logic [7:0]        tile_raw;
	logic [TILE_W-1:0] tile_sat;
	assign cxc      = (cx_q >= 13'(tc)) ? 13'(tc - 4'd1) : cx_q;
	assign cyc      = (cy_q >= 13'(tr)) ? 13'(tr - 4'd1) : cy_q;
	assign tile_raw = 8'(cyc[3:0]) * 8'(tc) + 8'(cxc[3:0]);
	assign tile_sat = (32'(tile_raw) >= MAX_TILES) ? TILE_W'(MAX_TILES - 1)
	                                               : TILE_W'(tile_raw);

	// ---------------- multiply-accumulate ----------------
	logic [ADDR_W-1:0]      raddr;
	logic [VALUE_BITS-1:0]  rdata;
	logic [33:0]            wprod;
	logic [33:0]            wsum;
	logic [16:0]            w_s1;
	logic                   v_s1, v_s2;
	logic signed [PROD_W-1:0] prod_s2;

	assign raddr = ADDR_W'(base_q + ADDR_W'(k_q));
	assign wprod = 34'(bu_q[i_q]) * 34'(bv_q[j_q]);
	assign wsum  = wprod + 34'(32768);

	bse_knot_ram #(
		.DEPTH  (DEPTH),
		.WIDTH  (VALUE_BITS),
		.ADDR_W (ADDR_W)
	) u_ram (
		.clk   (clk),
		.we    (kw_en),
		.waddr (ADDR_W'(knot_index)),
		.wdata (kv_sat[VALUE_BITS-1:0]),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= (state_q == bse_pkg::ST_MAC);
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		w_s1    <= wsum[32:16];
		prod_s2 <= $signed(rdata) * $signed({1'b0, w_s1});
	end

	// final rounding: half up from Q16 to an integer, saturate
	logic signed [ACC_W-1:0] acc_rnd;
	logic signed [Q_W-1:0]   q_full, q_sat;
	logic signed [OUT_BITS-1:0] q_n;
	logic [23:0]             surf;

	assign acc_rnd = acc_q + ACC_W'(32768);
	assign q_full  = $signed(acc_rnd[ACC_W-1:16]);
	assign q_sat   = (q_full > OUT_HI) ? OUT_HI : ((q_full < OUT_LO) ? OUT_LO : q_full);
	assign q_n     = q_sat[OUT_BITS-1:0];
	assign surf    = outside_q ? 24'hFFFF00 : 24'(q_n);

	logic out_free;
	assign out_free = !m_tvalid || m_tready;

	// ---------------- sequencer ----------------
	always_comb begin
		state_n = state_q;
		case (state_q)
			bse_pkg::ST_IDLE: begin
				if (eval_acc) begin
					state_n = (cx_cl.ok && cy_cl.ok) ? bse_pkg::ST_DIVX : bse_pkg::ST_FINAL;
				end
			end
			bse_pkg::ST_DIVX:   if (div_rsp.done) state_n = bse_pkg::ST_DIVY;
			bse_pkg::ST_DIVY:   if (div_rsp.done) state_n = bse_pkg::ST_FRX;
			bse_pkg::ST_FRX:    if (div_rsp.done) state_n = bse_pkg::ST_FRY;
			bse_pkg::ST_FRY:    if (div_rsp.done) state_n = bse_pkg::ST_BLX_SQ;
			bse_pkg::ST_BLX_SQ: state_n = bse_pkg::ST_BLX;
			bse_pkg::ST_BLX:    state_n = bse_pkg::ST_BLY_SQ;
			bse_pkg::ST_BLY_SQ: state_n = bse_pkg::ST_BLY;
			bse_pkg::ST_BLY:    state_n = bse_pkg::ST_TILE;
			bse_pkg::ST_TILE:   state_n = bse_pkg::ST_MAC;
			bse_pkg::ST_MAC: begin
				if (k_q == 5'(bse_pkg::KNOTS_PER_TILE - 1)) state_n = bse_pkg::ST_DRAIN;
			end
			bse_pkg::ST_DRAIN:  if (!v_s1 && !v_s2) state_n = bse_pkg::ST_FINAL;
			bse_pkg::ST_FINAL:  if (out_free) state_n = bse_pkg::ST_IDLE;
			default:            state_n = bse_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= bse_pkg::ST_IDLE;
			launched_q <= 1'b0;
			m_tvalid   <= 1'b0;
		end else begin
			state_q <= state_n;
			if (div_req.start) begin
				launched_q <= 1'b1;
			end else if (div_rsp.done) begin
				launched_q <= 1'b0;
			end
			if (state_q == bse_pkg::ST_FINAL && out_free) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			bse_pkg::ST_IDLE: begin
				px_q      <= cx_cl.val;
				py_q      <= cy_cl.val;
				outside_q <= !(cx_cl.ok && cy_cl.ok);
			end
			bse_pkg::ST_DIVX: begin
				if (div_rsp.done) begin
					cx_q <= div_rsp.quo[12:0];
					rx_q <= div_rsp.rem;
				end
			end
			bse_pkg::ST_DIVY: begin
				if (div_rsp.done) begin
					cy_q <= div_rsp.quo[12:0];
					ry_q <= div_rsp.rem;
				end
			end
			bse_pkg::ST_FRX:  if (div_rsp.done) sx_q <= div_rsp.quo[17:0];
			bse_pkg::ST_FRY:  if (div_rsp.done) sy_q <= div_rsp.quo[17:0];
			bse_pkg::ST_BLX_SQ, bse_pkg::ST_BLY_SQ: begin
				seg_q  <= s_sel[17:16];
				t_q    <= s_sel[15:0];
				t2_q   <= s_sel[15:0] * s_sel[15:0];
				omt2_q <= 33'(omt) * 33'(omt);
			end
			bse_pkg::ST_BLX:  bu_q <= bse_pkg::blend(seg_q, t_q, t2_q, omt2_q);
			bse_pkg::ST_BLY:  bv_q <= bse_pkg::blend(seg_q, t_q, t2_q, omt2_q);
			bse_pkg::ST_TILE: begin
				base_q <= ADDR_W'(32'(tile_sat) * bse_pkg::KNOTS_PER_TILE);
				acc_q  <= '0;
				k_q    <= '0;
				i_q    <= '0;
				j_q    <= '0;
			end
			bse_pkg::ST_MAC: begin
				k_q <= k_q + 5'd1;
				if (i_q == 3'(bse_pkg::GRID - 1)) begin
					i_q <= '0;
					j_q <= j_q + 3'd1;
				end else begin
					i_q <= i_q + 3'd1;
				end
			end
			bse_pkg::ST_FINAL: begin
				if (out_free) begin
					m_tdata <= surf;
					m_tuser <= outside_q;
				end
			end
			default: ;
		endcase
		if (v_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
	end

`ifndef SYNTHESIS
	a_outside_value: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == 24'hFFFF00)
		else $error("outside result without the outside value");

	a_write_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == bse_pkg::OP_WRITE) && !m_tvalid |=> !m_tvalid)
		else $error("write request produced a result");

	a_mac_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == bse_pkg::ST_MAC |-> k_q < 5'(bse_pkg::KNOTS_PER_TILE))
		else $error("accumulate counter ran past the tile");

	a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !v_s2 && !launched_q)
		else $error("ready while evaluation still in flight");
`endif

endmodule

// ===== test/tb_top.sv =====
module tb_top;
	import bse_pkg::*;

	localparam int  STORE_DEPTH = MAX_TILES_DEF * KNOTS_PER_TILE;
	localparam int  CYCLE_LIMIT = 2_000_000;
	// time left for a write request to settle before a register write
	localparam int  SETTLE      = 8;
	// tiles the geometry can reach, besides the saturated last tile
	localparam int  FILL_TILES  = 8;

	typedef struct {
		logic [OUT_W-1:0] value;
		logic             outside;
	} surface_t;

	typedef longint unsigned blend_row_t [GRID];

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [71:0] s_tdata = '0;   // knot_index, knot_value, point_x, point_y, zero pad
	logic        s_tuser = OP_WRITE;   // opcode
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;        // surface_value
	logic        m_tuser;        // outside
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	bspline_surface_eval u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// shadow copy of the block's registers and knot store
	logic [15:0]       shadow_reg [8];
	longint            knots [STORE_DEPTH];
	surface_t          pending_surface [$];
	int                errors = 0;
	int                evals_sent = 0;
	int                writes_sent = 0;
	int                results_seen = 0;
	int                outside_seen = 0;
	int                cycles = 0;
	bit                no_stall = 1'b0;   // stretch with no idling on either side

	function automatic logic [15:0] reg_mask(int r, logic [15:0] v);
		case (cfg_reg_t'(r))
			REG_ORIGIN_X, REG_ORIGIN_Y:       return v;
			REG_TILE_COLUMNS, REG_TILE_ROWS:  return v & 16'h000F;
			default:                          return v & 16'h1FFF;
		endcase
	endfunction

	function automatic longint floor_of(logic [15:0] v, longint m);
		return (longint'(v) < m) ? m : longint'(v);
	endfunction

	// Q16 blends of the three-segment quadratic basis at r in a tile of n+1 pixels
	function automatic blend_row_t spline_blends(longint unsigned r, longint unsigned n);
		longint unsigned s, seg, t, t2, one;
		longint unsigned d [GRID];
		blend_row_t      b;
		one = 65536;
		s   = r * 196608 / n;
		seg = s >> 16;
		t   = s & 16'hFFFF;
		t2  = t * t;
		for (int k = 0; k < GRID; k++) d[k] = 0;
		case (seg)
			0: begin
				d[0] = 2 * (one - t) * (one - t);
				d[1] = 4 * t * one - 3 * t2;
				d[2] = t2;
			end
			1: begin
				d[1] = (one - t) * (one - t);
				d[2] = one * one + 2 * t * one - 2 * t2;
				d[3] = t2;
			end
			2: begin
				d[2] = (one - t) * (one - t);
				d[3] = one * one + 2 * t * one - 3 * t2;
				d[4] = 2 * t2;
			end
			default: d[4] = 2 * one * one;
		endcase
		for (int k = 0; k < GRID; k++) b[k] = (d[k] + 65536) >> 17;
		return b;
	endfunction

	// clamp an offset into [0, size-1] within tolerance; 0 when outside
	function automatic bit pull_to_edge(inout longint p, input longint size);
		if (p < 0) begin
			if (p > -EDGE_TOLERANCE_DEF) p = 0;
			else return 1'b0;
		end
		if (p >= size) begin
			if (p < size + EDGE_TOLERANCE_DEF) p = size - 1;
			else return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic surface_t surface_at(logic [15:0] ptx, logic [15:0] pty);
		longint     px, py, iw, ih, tw, th, tc, tr, cx, cy, tile, acc, q, hi;
		blend_row_t bu, bv;
		longint     w;
		surface_t   res;
		iw = floor_of(shadow_reg[REG_IMAGE_WIDTH], 2);
		ih = floor_of(shadow_reg[REG_IMAGE_HEIGHT], 2);
		px = longint'($signed(ptx)) - longint'($signed(shadow_reg[REG_ORIGIN_X]));
		py = longint'($signed(pty)) - longint'($signed(shadow_reg[REG_ORIGIN_Y]));
		if (!pull_to_edge(px, iw) || !pull_to_edge(py, ih)) begin
			res.value   = 24'hFFFF00;
			res.outside = 1'b1;
			return res;
		end
		tw = floor_of(shadow_reg[REG_TILE_WIDTH], 2);
		th = floor_of(shadow_reg[REG_TILE_HEIGHT], 2);
		tc = floor_of(shadow_reg[REG_TILE_COLUMNS], 1);
		tr = floor_of(shadow_reg[REG_TILE_ROWS], 1);
		cx = px / tw;
		cy = py / th;
		if (cx >= tc) cx = tc - 1;
		if (cy >= tr) cy = tr - 1;
		tile = cy * tc + cx;
		if (tile >= MAX_TILES_DEF) tile = MAX_TILES_DEF - 1;
		bu  = spline_blends(px % tw, tw - 1);
		bv  = spline_blends(py % th, th - 1);
		acc = 0;
		for (int j = 0; j < GRID; j++)
			for (int i = 0; i < GRID; i++) begin
				w   = longint'((bu[i] * bv[j] + 32768) >> 16);
				acc += knots[tile * KNOTS_PER_TILE + j * GRID + i] * w;
			end
		q  = (acc + 32768) >>> 16;   // round half up, floor division
		hi = (64'sd1 <<< (OUT_W - 1)) - 1;
		if (q > hi) q = hi;
		if (q < -hi - 1) q = -hi - 1;
		res.value   = q[OUT_W-1:0];
		res.outside = 1'b0;
		return res;
	endfunction

	// result side: random stall per result, compare against the oldest prediction
	int ready_hold = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				surface_t exp_s;
				results_seen++;
				if (m_tuser) outside_seen++;
				if (pending_surface.size() == 0) begin
					$error("unexpected result: surface_value %0d outside %0b",
						$signed(m_tdata), m_tuser);
					errors++;
				end else begin
					exp_s = pending_surface.pop_front();
					if (m_tdata !== exp_s.value) begin
						$error("surface_value: expected %0d, got %0d",
							$signed(exp_s.value), $signed(m_tdata));
						errors++;
					end
					if (m_tuser !== exp_s.outside) begin
						$error("outside: expected %0b, got %0b", exp_s.outside, m_tuser);
						errors++;
					end
				end
				ready_hold = no_stall ? 0 : $urandom_range(0, 16);
			end
			if (ready_hold > 0) begin
				m_tready <= 1'b0;
				ready_hold--;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// one request; valid stays high into the next request unless a gap is drawn
	task automatic send_request(logic op, logic [10:0] idx, logic [23:0] val,
			logic [15:0] ptx, logic [15:0] pty);
		int gap;
		gap = no_stall ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {5'b0, pty, ptx, val, idx};
		do @(posedge clk); while (!s_tready);
		if (op == OP_WRITE) begin
			writes_sent++;
			if (idx < STORE_DEPTH) knots[idx] = longint'($signed(val));
		end else begin
			evals_sent++;
			pending_surface = {pending_surface, surface_at(ptx, pty)};
		end
	endtask

	task automatic write_knot(int idx, logic [23:0] val);
		send_request(OP_WRITE, 11'(idx), val, 16'($urandom), 16'($urandom));
	endtask

	task automatic eval_point(longint x, longint y);
		send_request(OP_EVAL, 11'($urandom), 24'($urandom), 16'(x), 16'(y));
	endtask

	task automatic wait_drained;
		s_tvalid <= 1'b0;
		while (pending_surface.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// all eight registers, only while idle
	task automatic load_registers(logic [15:0] v [8]);
		wait_drained();
		for (int r = 0; r < 8; r++) begin
			cfg_valid <= 1'b1;
			cfg_index <= 3'(r);
			cfg_data  <= v[r];
			do @(posedge clk); while (!cfg_ready);
			shadow_reg[r] = reg_mask(r, v[r]);
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic load_geometry(int ox, int oy, int iw, int ih, int tc, int tr, int tw, int th);
		logic [15:0] v [8];
		v[REG_ORIGIN_X] = 16'(ox);      v[REG_ORIGIN_Y] = 16'(oy);
		v[REG_IMAGE_WIDTH] = 16'(iw);   v[REG_IMAGE_HEIGHT] = 16'(ih);
		v[REG_TILE_COLUMNS] = 16'(tc);  v[REG_TILE_ROWS] = 16'(tr);
		v[REG_TILE_WIDTH] = 16'(tw);    v[REG_TILE_HEIGHT] = 16'(th);
		load_registers(v);
	endtask

	// every tile the tests can reach gets written before any evaluation reads it
	task automatic test_fill_store;
		int idx;
		for (int i = 0; i < (FILL_TILES + 1) * KNOTS_PER_TILE; i++) begin
			idx = (i < FILL_TILES * KNOTS_PER_TILE) ? i
			      : i + (MAX_TILES_DEF - 1 - FILL_TILES) * KNOTS_PER_TILE;
			case (i % 7)
				0:       write_knot(idx, 24'h7FFFFF);
				1:       write_knot(idx, 24'h800000);
				default: write_knot(idx, 24'($urandom));
			endcase
		end
	endtask

	task automatic test_directed;
		// tile 0 all at full scale, then corners and tolerance edges at reset geometry
		for (int i = 0; i < KNOTS_PER_TILE; i++) write_knot(i, 24'h7FFFFF);
		eval_point(0, 0);
		eval_point(639, 479);
		eval_point(-24, 0);          // just inside tolerance
		eval_point(-25, 0);          // just outside
		eval_point(664, 100);
		eval_point(665, 100);
		eval_point(100, 504);
		eval_point(-32768, 32767);
		write_knot(2047, 24'h123456);   // beyond the store, dropped
		write_knot(STORE_DEPTH, 24'h000001);
		for (int i = 0; i < KNOTS_PER_TILE; i++) write_knot(i, 24'h800000);
		eval_point(320, 240);
		// grid filling all 64 tiles, small tiles, extreme origin
		load_geometry(-32768, 32767, 4096, 4096, 8, 8, 512, 512);
		eval_point(-32768, 32767);
		eval_point(32767, -32768);
		eval_point(-32768 + 4095, 32767);
		// sizes below the floor act as the floor
		load_geometry(0, 0, 0, 1, 0, 0, 1, 0);
		eval_point(0, 0);
		eval_point(1, 1);
		eval_point(3, 2);
		// a tile grid beyond the store clamps to the last tile
		load_geometry(100, -100, 8191, 8191, 15, 15, 8191, 2);
		eval_point(100 + 8190, -100 + 8190);
		eval_point(120, -80);
	endtask

	// tile count kept within the filled tiles
	task automatic random_geometry;
		logic [15:0] v [8];
		int tc, tr, tw, th;
		if ($urandom_range(0, 4) == 0) begin
			for (int r = 0; r < 8; r++) v[r] = 16'($urandom);
			v[REG_TILE_COLUMNS] = {12'($urandom), 4'($urandom_range(0, FILL_TILES))};
			v[REG_TILE_ROWS]    = {12'($urandom), 4'($urandom_range(0, 1))};
			load_registers(v);
		end else begin
			tc = $urandom_range(1, FILL_TILES);
			tr = $urandom_range(1, FILL_TILES / tc);
			tw = $urandom_range(0, 5) == 0 ? $urandom_range(2, 512) : $urandom_range(2, 40);
			th = $urandom_range(0, 5) == 0 ? $urandom_range(2, 512) : $urandom_range(2, 40);
			load_geometry($urandom, $urandom, tc * tw, tr * th, tc, tr, tw, th);
		end
	endtask

	task automatic test_random;
		longint ox, oy, iw, ih;
		for (int phase = 0; phase < 7; phase++) begin
			random_geometry();
			no_stall = (phase == 3);
			ox = longint'($signed(shadow_reg[REG_ORIGIN_X]));
			oy = longint'($signed(shadow_reg[REG_ORIGIN_Y]));
			iw = floor_of(shadow_reg[REG_IMAGE_WIDTH], 2);
			ih = floor_of(shadow_reg[REG_IMAGE_HEIGHT], 2);
			for (int n = 0; n < 30; n++) begin
				if (n == 15) wait_drained();   // let the pipe empty mid-phase
				case ($urandom_range(0, 9))
					0, 1:    write_knot($urandom_range(0, STORE_DEPTH - 1), 24'($urandom));
					2:       write_knot($urandom_range(0, 2047), 24'($urandom));
					3:       eval_point($urandom, $urandom);
					default: eval_point(ox + $urandom_range(0, iw + 59) - 30,
					                    oy + $urandom_range(0, ih + 59) - 30);
				endcase
			end
			no_stall = 1'b0;
		end
	endtask

	initial begin
		for (int r = 0; r < 8; r++) shadow_reg[r] = '0;
		shadow_reg[REG_IMAGE_WIDTH]  = 16'd640;
		shadow_reg[REG_IMAGE_HEIGHT] = 16'd480;
		shadow_reg[REG_TILE_COLUMNS] = 16'd1;
		shadow_reg[REG_TILE_ROWS]    = 16'd1;
		shadow_reg[REG_TILE_WIDTH]   = 16'd640;
		shadow_reg[REG_TILE_HEIGHT]  = 16'd480;
		for (int i = 0; i < STORE_DEPTH; i++) knots[i] = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_fill_store();
		test_directed();
		test_random();
		wait_drained();
		repeat (200) @(posedge clk);
		$display("covered %0d knot writes and %0d evaluations, %0d results (%0d outside)",
			writes_sent, evals_sent, results_seen, outside_seen);
		if (errors == 0 && pending_surface.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
